@@ src/rvalu_pkg.sv @@
// Package for the RV32IM integer ALU pipeline: operation codes and the item
// record that travels down the stages. No dependencies.
package rvalu_pkg;

    localparam int unsigned XLEN    = 32;
    localparam int unsigned OP_W    = 5;
    localparam int unsigned SHAMT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_XOR    = 5'd2,
        OP_OR     = 5'd3,
        OP_AND    = 5'd4,
        OP_SLL    = 5'd5,
        OP_SRL    = 5'd6,
        OP_SRA    = 5'd7,
        OP_SLT    = 5'd8,
        OP_SLTU   = 5'd9,
        OP_MUL    = 5'd10,
        OP_MULH   = 5'd11,
        OP_MULHSU = 5'd12,
        OP_MULHU  = 5'd13,
        OP_DIV    = 5'd14,
        OP_DIVU   = 5'd15,
        OP_REM    = 5'd16,
        OP_REMU   = 5'd17
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [XLEN-1:0]   simple;
        logic              neg_q;
        logic              neg_r;
        logic              neg_p;
        logic              bz;
        logic [2*XLEN-1:0] prod;
        logic [XLEN-1:0]   quo;
        logic [XLEN-1:0]   rem;
        logic [XLEN-1:0]   dvs;
    } t_item;

endpackage

@@ src/rv32im_integer_alu_unit.sv @@
// Top level of the pipelined RV32IM integer ALU.
// Depends on rvalu_pkg, rvalu_front, rvalu_mul, rvalu_div_step, rvalu_back.
//
//   channel | handshake           | fields
//   in      | i_valid / o_ready   | i_op, i_operand_a, i_operand_b
//   out     | o_valid / i_ready   | o_result
//
// Every item passes the entry stage, two multiply stages, 32 divide stages
// (one quotient bit each) and the result stage; one item per cycle unless the output stalls.
// Each stage has its own valid bit and accepts when empty or draining, so
// bubbles collapse under a stalled output. Reset clears all valid bits.
module rv32im_integer_alu_unit import rvalu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [OP_W-1:0] i_op,
    input  logic [XLEN-1:0] i_operand_a,
    input  logic [XLEN-1:0] i_operand_b,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [XLEN-1:0] o_result
);
    logic  v_front;
    logic  rdy_mul;
    t_item it_front;
    logic  v_div   [XLEN+1];
    logic  rdy_div [XLEN+1];
    t_item it_div  [XLEN+1];

    rvalu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (v_front),
        .i_ready     (rdy_mul),
        .o_item      (it_front)
    );

    rvalu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_front),
        .o_ready (rdy_mul),
        .i_item  (it_front),
        .o_valid (v_div[0]),
        .i_ready (rdy_div[0]),
        .o_item  (it_div[0])
    );

    for (genvar k = 0; k < XLEN; k++) begin : g_div
        rvalu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_div[k]),
            .o_ready (rdy_div[k]),
            .i_item  (it_div[k]),
            .o_valid (v_div[k+1]),
            .i_ready (rdy_div[k+1]),
            .o_item  (it_div[k+1])
        );
    end

    rvalu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (v_div[XLEN]),
        .o_ready  (rdy_div[XLEN]),
        .i_item   (it_div[XLEN]),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );
endmodule

@@ src/rvalu_front.sv @@
// Entry stage: the simple ALU operations and operand magnitudes for the
// multiply and divide stages. Depends on rvalu_pkg.
module rvalu_front import rvalu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [XLEN-1:0]     i_operand_a,
    input  logic [XLEN-1:0]     i_operand_b,
    output logic                o_valid,
    input  logic                i_ready,
    output t_item               o_item
);
    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic [SHAMT_W-1:0] sh;
    logic               sgn_a;
    logic               sgn_b;
    logic [XLEN-1:0]    simple;

    assign sh      = i_operand_b[SHAMT_W-1:0];
    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        unique case (i_op)
            OP_ADD:  simple = i_operand_a + i_operand_b;
            OP_SUB:  simple = i_operand_a - i_operand_b;
            OP_XOR:  simple = i_operand_a ^ i_operand_b;
            OP_OR:   simple = i_operand_a | i_operand_b;
            OP_AND:  simple = i_operand_a & i_operand_b;
            OP_SLL:  simple = i_operand_a << sh;
            OP_SRL:  simple = i_operand_a >> sh;
            OP_SRA:  simple = XLEN'($signed(i_operand_a) >>> sh);
            OP_SLT:  simple = {{(XLEN-1){1'b0}},
                               $signed(i_operand_a) < $signed(i_operand_b)};
            OP_SLTU: simple = {{(XLEN-1){1'b0}}, i_operand_a < i_operand_b};
            default: simple = '0;
        endcase
    end

    always_comb begin
        sgn_a = i_operand_a[XLEN-1] & ((i_op == OP_MULH) || (i_op == OP_MULHSU) ||
                                       (i_op == OP_DIV) || (i_op == OP_REM));
        sgn_b = i_operand_b[XLEN-1] & ((i_op == OP_MULH) || (i_op == OP_DIV) ||
                                       (i_op == OP_REM));
        n_item        = '0;
        n_item.op     = i_op;
        n_item.simple = simple;
        n_item.neg_p  = sgn_a ^ sgn_b;
        n_item.neg_q  = sgn_a ^ sgn_b;
        n_item.neg_r  = sgn_a;
        n_item.bz     = (i_operand_b == '0);
        n_item.quo    = sgn_a ? (~i_operand_a + 1'b1) : i_operand_a;
        n_item.dvs    = sgn_b ? (~i_operand_b + 1'b1) : i_operand_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end
endmodule

@@ src/rvalu_mul.sv @@
// Two multiply stages: unsigned 32x32 product of magnitudes, then sign fix.
// Depends on rvalu_pkg.
module rvalu_mul import rvalu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    logic  r_v1;
    logic  r_v2;
    t_item r_i1;
    t_item r_i2;
    t_item n_i1;
    t_item n_i2;
    logic  rdy2;

    assign rdy2    = ~r_v2 | i_ready;
    assign o_ready = ~r_v1 | rdy2;
    assign o_valid = r_v2;
    assign o_item  = r_i2;

    always_comb begin
        n_i1      = i_item;
        n_i1.prod = i_item.quo * i_item.dvs;
        n_i2      = r_i1;
        n_i2.prod = r_i1.neg_p ? (~r_i1.prod + 1'b1) : r_i1.prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (rdy2)    r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_i1 <= n_i1;
        if (rdy2 && r_v1)       r_i2 <= n_i2;
    end
endmodule

@@ src/rvalu_div_step.sv @@
// One restoring-division stage: one quotient bit per stage.
// Depends on rvalu_pkg.
module rvalu_div_step import rvalu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    logic            r_valid;
    t_item           r_item;
    t_item           n_item;
    logic [XLEN:0]   trial;
    logic [XLEN:0]   diff;
    logic            ge;

    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        trial      = {i_item.rem, i_item.quo[XLEN-1]};
        diff       = trial - {1'b0, i_item.dvs};
        ge         = trial >= {1'b0, i_item.dvs};
        n_item     = i_item;
        n_item.rem = ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
        n_item.quo = {i_item.quo[XLEN-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end
endmodule

@@ src/rvalu_back.sv @@
// Result stage: picks the result by operation and fixes divide signs.
// Depends on rvalu_pkg.
module rvalu_back import rvalu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_item           i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [XLEN-1:0] o_result
);
    logic            r_valid;
    logic [XLEN-1:0] r_result;
    logic [XLEN-1:0] n_result;
    logic [XLEN-1:0] q_fix;
    logic [XLEN-1:0] r_fix;

    assign o_ready  = ~r_valid | i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        q_fix = i_item.neg_q ? (~i_item.quo + 1'b1) : i_item.quo;
        r_fix = i_item.neg_r ? (~i_item.rem + 1'b1) : i_item.rem;
        unique case (i_item.op)
            OP_MUL:                       n_result = i_item.prod[XLEN-1:0];
            OP_MULH, OP_MULHSU, OP_MULHU: n_result = i_item.prod[2*XLEN-1:XLEN];
            OP_DIV:                       n_result = i_item.bz ? '1 : q_fix;
            OP_DIVU:                      n_result = i_item.quo;
            OP_REM:                       n_result = r_fix;
            OP_REMU:                      n_result = i_item.rem;
            default:                      n_result = i_item.simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end
endmodule
